/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the chunk header compressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define RCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define RCC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RCC_ASSERT(lbl, clk, rstn, prop, msg)
`define RCC_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/core/rcc_pkg.sv */
// Package with types, constants and codes of the chunk header compressor.
package rcc_pkg;

  // Channel table size.
  localparam int CHANNELS_DEF = 64;

  // Field widths.
  localparam int CHUNK_W = 17;
  localparam int CID_W   = 6;
  localparam int LEN_W   = 24;
  localparam int CFG_IDX_W = 3;

  // Output burst: at most 16 bytes for one item.
  localparam int BURST_MAX = 16;
  localparam int CNT_W     = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVOKE_CHAN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_CHAN = 3'd4;

  // Register reset values.
  localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RST   = 17'd128;
  localparam logic [CID_W-1:0]   VIDEO_BASE_RST   = 6'd4;
  localparam logic [CID_W-1:0]   OTHER_BASE_RST   = 6'd5;
  localparam logic [CID_W-1:0]   INVOKE_CHAN_RST  = 6'd3;
  localparam logic [CID_W-1:0]   CONTROL_CHAN_RST = 6'd2;

  // Chunk size limits.
  localparam logic [CHUNK_W-1:0] CHUNK_MIN = 17'd1;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX = 17'd65536;

  // Message type codes.
  localparam logic [7:0] TYPE_AUDIO    = 8'd8;
  localparam logic [7:0] TYPE_VIDEO    = 8'd9;
  localparam logic [7:0] TYPE_META     = 8'd18;
  localparam logic [7:0] TYPE_INVOKE   = 8'd20;
  localparam logic [7:0] TYPE_CTRL_MAX = 8'd6;

  // Chunk header formats.
  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_LEN   = 2'd1;
  localparam logic [1:0] FMT_STAMP = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  // Timestamp escape value and continuation header marker.
  localparam logic [23:0] TS_EXT   = 24'hFFFFFF;
  localparam logic [1:0]  CONT_FMT = 2'b11;

  // Input item as carried on tdata, first field in the highest bits.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] msg_len;
    logic [31:0]      ts_offset;
    logic [31:0]      epoch;
    logic [7:0]       msg_type;
    logic [31:0]      sid;
  } in_item_t;

  // One channel table entry.
  typedef struct packed {
    logic [31:0]      stream;
    logic [7:0]       rtype;
    logic [LEN_W-1:0] length;
    logic [31:0]      stamp;
    logic [31:0]      epoch;
  } chan_entry_t;

  // Bytes of one item, byte 0 goes out first.
  typedef logic [BURST_MAX-1:0][7:0] burst_bytes_t;

  typedef struct packed {
    logic                 load;
    burst_bytes_t         bytes;
    logic [BURST_MAX-1:0] hdr;
    logic [CNT_W-1:0]     count;
  } burst_t;

endpackage

/* rtl/core/rcc_chan_table.sv */
// Memory holding the last message sent on each chunk id.
module rcc_chan_table
  import rcc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(CHANNELS)-1:0] rd_addr,
  output chan_entry_t                 rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(CHANNELS)-1:0] wr_addr,
  input  chan_entry_t                 wr_data
);

  chan_entry_t mem [CHANNELS];
  chan_entry_t rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/rcc_out_buf.sv */
// Output shift register that sends the bytes of one item, one per transfer.
module rcc_out_buf
  import rcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  burst_t     burst,
  output logic       free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tuser,   // is_header
  output logic       out_tlast
);

  burst_bytes_t         data_r;
  logic [BURST_MAX-1:0] hdr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 xfer;

  assign xfer       = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign out_tdata  = data_r[0];
  assign out_tuser  = hdr_r[0];
  // Room for a new burst when the buffer is empty or once the last byte leaves in this cycle.
  assign free       = !out_tvalid || (xfer && out_tlast);

  // Byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (burst.load) begin
      cnt_r <= burst.count;
    end else if (xfer) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Payload shift register.
  always_ff @(posedge clk) begin
    if (burst.load) begin
      data_r <= burst.bytes;
      hdr_r  <= burst.hdr;
    end else if (xfer) begin
      data_r <= data_r >> 8;
      hdr_r  <= hdr_r >> 1;
    end
  end

endmodule

/* rtl/core/rtmp_chunk_header_compressor_top.sv */
// Top level of the chunk header compressor: chunk id pick, format choice, byte output.
// An accepted item is held in the input register, then loaded into the output buffer.
// Throughput: one input item per cycle while the output buffer is free; a header item
// puts up to 16 bytes on the byte-wide output, a payload byte 1, or 2 at a chunk boundary.
// Reset (synchronous, active low) clears the channel valid bits, the message counters
// and the registers to their defaults; the table memory itself is not swept.
module rtmp_chunk_header_compressor_top
  import rcc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [135:0]         in_tdata,   // sid, msg_type, epoch, ts_offset, msg_len,
                                           // data_byte
  input  logic                 in_tuser,   // cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // out_byte
  output logic                 out_tuser,  // is_header
  output logic                 out_tlast,  // last
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHUNK_W-1:0]   cfg_wdata
);

`include "assert_macros.svh"

  localparam int         SLOT_W = $clog2(CHANNELS);
  localparam logic [6:0] CH7    = 7'(CHANNELS);

  // Reduce a chunk id to a table slot by repeated subtraction.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [CID_W-1:0] c);
    logic [6:0] v;
    v = {1'b0, c};
    for (int i = 0; i < 8; i++) begin
      if (v >= CH7) begin
        v = v - CH7;
      end
    end
    return v[SLOT_W-1:0];
  endfunction

  // Configuration registers.
  logic [CHUNK_W-1:0] chunk_size_r;
  logic [CID_W-1:0]   video_base_r;
  logic [CID_W-1:0]   other_base_r;
  logic [CID_W-1:0]   invoke_chan_r;
  logic [CID_W-1:0]   control_chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r   <= CHUNK_SIZE_RST;
      video_base_r   <= VIDEO_BASE_RST;
      other_base_r   <= OTHER_BASE_RST;
      invoke_chan_r  <= INVOKE_CHAN_RST;
      control_chan_r <= CONTROL_CHAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNK_SIZE:   chunk_size_r   <= cfg_wdata;
        CFG_VIDEO_BASE:   video_base_r   <= cfg_wdata[CID_W-1:0];
        CFG_OTHER_BASE:   other_base_r   <= cfg_wdata[CID_W-1:0];
        CFG_INVOKE_CHAN:  invoke_chan_r  <= cfg_wdata[CID_W-1:0];
        CFG_CONTROL_CHAN: control_chan_r <= cfg_wdata[CID_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode: chunk id, slot and effective timestamp.
  in_item_t          item;
  logic [CID_W-1:0]  twice6;
  logic [CID_W-1:0]  in_cid;
  logic [SLOT_W-1:0] in_slot;
  logic [31:0]       in_epoch;
  logic              in_acc;

  assign item   = in_item_t'(in_tdata);
  assign twice6 = {item.sid[CID_W-2:0], 1'b0};
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    if (item.msg_type == TYPE_VIDEO) begin
      in_cid = twice6 + video_base_r;
    end else if (item.msg_type inside {TYPE_AUDIO, TYPE_META}) begin
      in_cid = twice6 + other_base_r;
    end else if (item.msg_type == TYPE_INVOKE) begin
      in_cid = (item.sid == '0) ? invoke_chan_r : video_base_r;
    end else if (item.msg_type <= TYPE_CTRL_MAX) begin
      in_cid = control_chan_r;
    end else begin
      in_cid = other_base_r;
    end
  end

  assign in_slot  = slot_of(in_cid);
  assign in_epoch = (item.msg_type inside {TYPE_AUDIO, TYPE_VIDEO, TYPE_META}) ?
                    item.epoch + item.ts_offset : item.epoch;

  // Input register stage.
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [31:0]       s1_sid_r;
  logic [7:0]        s1_type_r;
  logic [31:0]       s1_epoch_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [7:0]        s1_data_r;
  logic [CID_W-1:0]  s1_cid_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_adv;
  logic              buf_free;

  assign s1_adv    = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_tuser;
      s1_sid_r   <= item.sid;
      s1_type_r  <= item.msg_type;
      s1_epoch_r <= in_epoch;
      s1_len_r   <= item.msg_len;
      s1_data_r  <= item.data_byte;
      s1_cid_r   <= in_cid;
      s1_slot_r  <= in_slot;
    end
  end

  // Channel table, with a bypass for a write to the slot being read.
  chan_entry_t       tbl_rd;
  chan_entry_t       wr_ent;
  chan_entry_t       byp_ent_r;
  chan_entry_t       ent;
  logic              byp_r;
  logic              tbl_we;
  logic [CHANNELS-1:0] valid_r;

  assign tbl_we = s1_adv && !s1_cmd_r;

  rcc_chan_table #(
    .CHANNELS(CHANNELS)
  ) u_table (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_slot),
    .rd_data (tbl_rd),
    .wr_en   (tbl_we),
    .wr_addr (s1_slot_r),
    .wr_data (wr_ent)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_r     <= tbl_we && (s1_slot_r == in_slot);
      byp_ent_r <= wr_ent;
    end
  end

  assign ent = byp_r ? byp_ent_r : tbl_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (tbl_we) begin
      valid_r[s1_slot_r] <= 1'b1;
    end
  end

  // Format choice for a header item.
  logic [32:0] diff;
  logic        new_chan;
  logic [31:0] ts;
  logic [1:0]  fmt;
  logic        ext;
  logic [23:0] ts24;

  assign diff     = {1'b0, s1_epoch_r} - {1'b0, ent.epoch};
  assign new_chan = !valid_r[s1_slot_r] || (s1_sid_r != ent.stream) || diff[32];
  assign ts       = new_chan ? s1_epoch_r : diff[31:0];
  assign ext      = (ts[31:24] != '0) || (ts[23:0] == TS_EXT);
  assign ts24     = ext ? TS_EXT : ts[23:0];

  always_comb begin
    if (new_chan) begin
      fmt = FMT_FULL;
    end else if ((s1_len_r == ent.length) && (s1_type_r == ent.rtype)) begin
      fmt = (ts == ent.stamp) ? FMT_NONE : FMT_STAMP;
    end else begin
      fmt = FMT_LEN;
    end
  end

  assign wr_ent = '{stream: s1_sid_r, rtype: s1_type_r, length: s1_len_r,
                    stamp: ts, epoch: s1_epoch_r};

  // Per-message payload state.
  logic [LEN_W-1:0]   bytes_left_r;
  logic [CHUNK_W-1:0] chunk_fill_r;
  logic [7:0]         cont_header_r;
  logic [CHUNK_W-1:0] size_eff;
  logic               need_cont;
  logic               pay_live;

  always_comb begin
    if (chunk_size_r == '0) begin
      size_eff = CHUNK_MIN;
    end else if (chunk_size_r > CHUNK_MAX) begin
      size_eff = CHUNK_MAX;
    end else begin
      size_eff = chunk_size_r;
    end
  end

  assign need_cont = (chunk_fill_r >= size_eff);
  assign pay_live  = (bytes_left_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r  <= '0;
      chunk_fill_r  <= '0;
      cont_header_r <= '0;
    end else if (s1_adv) begin
      if (!s1_cmd_r) begin
        bytes_left_r  <= s1_len_r;
        chunk_fill_r  <= '0;
        cont_header_r <= {CONT_FMT, s1_cid_r};
      end else if (pay_live) begin
        bytes_left_r <= bytes_left_r - LEN_W'(1);
        chunk_fill_r <= (need_cont ? '0 : chunk_fill_r) + CHUNK_W'(1);
      end
    end
  end

  // Assemble the bytes of the item.
  burst_t burst;

  always_comb begin
    burst       = '0;
    burst.load  = s1_adv && (s1_cmd_r ? pay_live : (s1_len_r != '0));
    if (!s1_cmd_r) begin
      burst.hdr       = '1;
      burst.bytes[0]  = {fmt, s1_cid_r};
      burst.bytes[1]  = ts24[23:16];
      burst.bytes[2]  = ts24[15:8];
      burst.bytes[3]  = ts24[7:0];
      // Slots 4..7 carry length and type, or the extended stamp for format 2.
      if (fmt == FMT_STAMP) begin
        burst.bytes[4] = ts[31:24];
        burst.bytes[5] = ts[23:16];
        burst.bytes[6] = ts[15:8];
        burst.bytes[7] = ts[7:0];
      end else begin
        burst.bytes[4] = s1_len_r[23:16];
        burst.bytes[5] = s1_len_r[15:8];
        burst.bytes[6] = s1_len_r[7:0];
        burst.bytes[7] = s1_type_r;
      end
      // Slots 8..11 carry the little-endian stream id, or the extended stamp.
      if (fmt == FMT_FULL) begin
        burst.bytes[8]  = s1_sid_r[7:0];
        burst.bytes[9]  = s1_sid_r[15:8];
        burst.bytes[10] = s1_sid_r[23:16];
        burst.bytes[11] = s1_sid_r[31:24];
      end else begin
        burst.bytes[8]  = ts[31:24];
        burst.bytes[9]  = ts[23:16];
        burst.bytes[10] = ts[15:8];
        burst.bytes[11] = ts[7:0];
      end
      burst.bytes[12] = ts[31:24];
      burst.bytes[13] = ts[23:16];
      burst.bytes[14] = ts[15:8];
      burst.bytes[15] = ts[7:0];
      case (fmt)
        FMT_FULL:  burst.count = ext ? CNT_W'(16) : CNT_W'(12);
        FMT_LEN:   burst.count = ext ? CNT_W'(12) : CNT_W'(8);
        FMT_STAMP: burst.count = ext ? CNT_W'(8)  : CNT_W'(4);
        default:   burst.count = CNT_W'(1);
      endcase
    end else if (need_cont) begin
      burst.bytes[0] = cont_header_r;
      burst.hdr[0]   = 1'b1;
      burst.bytes[1] = s1_data_r;
      burst.count    = CNT_W'(2);
    end else begin
      burst.bytes[0] = s1_data_r;
      burst.count    = CNT_W'(1);
    end
  end

  rcc_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst      (burst),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks on the stage handoff and the table update.
  `RCC_ASSERT(a_accept_fills, clk, rst_n, in_acc |=> s1_valid_r, "accepted item not held")
  `RCC_NEVER(a_load_busy, clk, rst_n, burst.load && !buf_free, "burst loaded over busy output")
  `RCC_ASSERT(a_slot_valid, clk, rst_n, tbl_we |=> valid_r[$past(s1_slot_r)], "slot not marked")

endmodule
